@@ design/mi3_pkg.sv @@
package mi3_pkg;

	// Field and datapath widths.
	localparam int EW    = 16;  // Q8.8 input entry
	localparam int PW    = 32;  // product of two entries
	localparam int MW    = 33;  // 2x2 minor and signed adjugate entry
	localparam int DW    = 49;  // signed determinant
	localparam int DMW   = 48;  // determinant magnitude
	localparam int QW    = 32;  // quotient magnitude and result entry
	localparam int STEPS = 32;  // divider steps, one quotient bit each
	localparam int LANES = 9;   // adjugate entries divided side by side

	typedef struct packed {
		logic signed [EW-1:0] m11;
		logic signed [EW-1:0] m12;
		logic signed [EW-1:0] m13;
		logic signed [EW-1:0] m21;
		logic signed [EW-1:0] m22;
		logic signed [EW-1:0] m23;
		logic signed [EW-1:0] m31;
		logic signed [EW-1:0] m32;
		logic signed [EW-1:0] m33;
	} mat_t;

	typedef struct packed {
		logic signed [QW-1:0] inv11;
		logic signed [QW-1:0] inv12;
		logic signed [QW-1:0] inv13;
		logic signed [QW-1:0] inv21;
		logic signed [QW-1:0] inv22;
		logic signed [QW-1:0] inv23;
		logic signed [QW-1:0] inv31;
		logic signed [QW-1:0] inv32;
		logic signed [QW-1:0] inv33;
		logic                 singular;
	} inv_t;

	localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
	localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

endpackage

@@ design/matrix_inverse_3x3.sv @@
// Fully pipelined 3x3 matrix inverse by adjugate. A Q8.8 matrix is taken on
// every clock edge at which start is high; busy is always low, because the
// pipeline never stalls. Each item yields exactly one result, shown on the
// result port for one cycle with done high. The receiver cannot hold results
// off and must take each one as it goes by. Five stages form the products,
// minors, determinant and magnitudes, one stage sets up the division,
// thirty-two stages each produce one quotient bit with a 49-bit compare and
// subtract, and a last stage applies sign and saturation. Results are
// Q16.16, truncated toward zero and saturated to 32 bits. A singular
// matrix gives all-zero entries with singular set.
module matrix_inverse_3x3 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mi3_pkg::mat_t  mat,
	output logic           done,
	output mi3_pkg::inv_t  res
);

	localparam int EW    = mi3_pkg::EW;
	localparam int PW    = mi3_pkg::PW;
	localparam int MW    = mi3_pkg::MW;
	localparam int DW    = mi3_pkg::DW;
	localparam int DMW   = mi3_pkg::DMW;
	localparam int QW    = mi3_pkg::QW;
	localparam int STEPS = mi3_pkg::STEPS;
	localparam int LANES = mi3_pkg::LANES;

	// The pipeline always moves, so a new item can be taken every cycle.
	assign busy = 1'b0;

	logic acc;
	assign acc = start;

	// Stage 1: the eighteen entry products, paired as a*b and c*d of each minor.
	logic signed [PW-1:0] pa_s1 [0:LANES-1];
	logic signed [PW-1:0] pb_s1 [0:LANES-1];
	logic signed [EW-1:0] row_s1 [0:2];
	logic                 vld_s1;

	// Stage 2: the nine minors.
	logic signed [MW-1:0] mn_s2 [0:LANES-1];
	logic signed [EW-1:0] row_s2 [0:2];
	logic                 vld_s2;

	// Stage 3: signed determinant terms and the adjugate.
	logic signed [DW-1:0] trm_s3 [0:2];
	logic signed [MW-1:0] adj_s3 [0:LANES-1];
	logic                 vld_s3;

	// Stage 4: determinant sum, adjugate magnitudes and signs.
	logic signed [DW-1:0] det_s4;
	logic [QW-1:0]        cmag_s4 [0:LANES-1];
	logic                 cneg_s4 [0:LANES-1];
	logic                 vld_s4;

	// Stage 5: determinant magnitude and sign.
	logic [DMW-1:0]       dmag_s5;
	logic                 dneg_s5;
	logic                 dzero_s5;
	logic [QW-1:0]        cmag_s5 [0:LANES-1];
	logic                 cneg_s5 [0:LANES-1];
	logic                 vld_s5;

	// Stage 6 onward: the divider. Index 0 is the setup stage, index k holds
	// the state after k quotient bits.
	logic [DMW-1:0] dv_rem_s6 [0:STEPS][0:LANES-1];
	logic [QW-1:0]  dv_q_s6   [0:STEPS][0:LANES-1];
	logic           dv_ovf_s6 [0:STEPS][0:LANES-1];
	logic           dv_neg_s6 [0:STEPS][0:LANES-1];
	logic [DMW-1:0] dv_d_s6   [0:STEPS];
	logic           dv_dz_s6  [0:STEPS];
	logic           dv_vld_s6 [0:STEPS];

	logic [QW-1:0]  ent [0:LANES-1];
	logic           done_q;
	mi3_pkg::inv_t  res_q;

	// Valid bits are the only control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			vld_s3       <= 1'b0;
			vld_s4       <= 1'b0;
			vld_s5       <= 1'b0;
			dv_vld_s6[0] <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			vld_s1       <= acc;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			dv_vld_s6[0] <= vld_s5;
			done_q       <= dv_vld_s6[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		// Minor k is pa - pb, in the order n11 n12 n13 n21 n22 n23 n31 n32 n33.
		pa_s1[0] <= mat.m22 * mat.m33;  pb_s1[0] <= mat.m23 * mat.m32;
		pa_s1[1] <= mat.m21 * mat.m33;  pb_s1[1] <= mat.m23 * mat.m31;
		pa_s1[2] <= mat.m21 * mat.m32;  pb_s1[2] <= mat.m22 * mat.m31;
		pa_s1[3] <= mat.m12 * mat.m33;  pb_s1[3] <= mat.m13 * mat.m32;
		pa_s1[4] <= mat.m11 * mat.m33;  pb_s1[4] <= mat.m13 * mat.m31;
		pa_s1[5] <= mat.m11 * mat.m32;  pb_s1[5] <= mat.m12 * mat.m31;
		pa_s1[6] <= mat.m12 * mat.m23;  pb_s1[6] <= mat.m13 * mat.m22;
		pa_s1[7] <= mat.m11 * mat.m23;  pb_s1[7] <= mat.m13 * mat.m21;
		pa_s1[8] <= mat.m11 * mat.m22;  pb_s1[8] <= mat.m12 * mat.m21;
		row_s1[0] <= mat.m11;
		row_s1[1] <= mat.m12;
		row_s1[2] <= mat.m13;

		for (int k = 0; k < LANES; k++) begin
			mn_s2[k] <= MW'(pa_s1[k]) - MW'(pb_s1[k]);
		end
		row_s2 <= row_s1;

		// Expansion along the first row, with the middle term subtracted.
		trm_s3[0] <= row_s2[0] * mn_s2[0];
		trm_s3[1] <= -(row_s2[1] * mn_s2[1]);
		trm_s3[2] <= row_s2[2] * mn_s2[2];
		// Adjugate entry (r,c) is minor (c,r) with a checkerboard sign.
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (((r + c) % 2) == 1) begin
					adj_s3[r*3+c] <= -mn_s2[c*3+r];
				end else begin
					adj_s3[r*3+c] <= mn_s2[c*3+r];
				end
			end
		end

		det_s4 <= trm_s3[0] + trm_s3[1] + trm_s3[2];
		for (int k = 0; k < LANES; k++) begin
			cneg_s4[k] <= adj_s3[k][MW-1];
			cmag_s4[k] <= adj_s3[k][MW-1] ? QW'(-adj_s3[k]) : QW'(adj_s3[k]);
		end

		dneg_s5  <= det_s4[DW-1];
		dzero_s5 <= (det_s4 == '0);
		dmag_s5  <= det_s4[DW-1] ? DMW'(-det_s4) : DMW'(det_s4);
		cmag_s5  <= cmag_s4;
		cneg_s5  <= cneg_s4;

		// Divider setup. The numerator is |C| << 24; its bits above 31 give the
		// starting remainder, and a quotient of 2^32 or more is flagged here.
		dv_d_s6[0]  <= dmag_s5;
		dv_dz_s6[0] <= dzero_s5;
		for (int k = 0; k < LANES; k++) begin
			dv_rem_s6[0][k] <= DMW'(cmag_s5[k][QW-1:8]);
			dv_q_s6[0][k]   <= {cmag_s5[k][7:0], 24'b0};
			dv_ovf_s6[0][k] <= DMW'(cmag_s5[k][QW-1:8]) >= dmag_s5;
			dv_neg_s6[0][k] <= cneg_s5[k] ^ dneg_s5;
		end
	end

	// One restoring step per stage: the quotient register shifts numerator bits
	// out at the top and quotient bits in at the bottom.
	for (genvar s = 1; s <= STEPS; s++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s6[s] <= 1'b0;
			end else begin
				dv_vld_s6[s] <= dv_vld_s6[s-1];
			end
		end

		always_ff @(posedge clk) begin
			dv_d_s6[s]  <= dv_d_s6[s-1];
			dv_dz_s6[s] <= dv_dz_s6[s-1];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DMW:0] shf;
			logic [DMW:0] dif;
			logic         ge;

			assign shf = {dv_rem_s6[s-1][l], dv_q_s6[s-1][l][QW-1]};
			assign dif = shf - {1'b0, dv_d_s6[s-1]};
			assign ge  = (shf >= {1'b0, dv_d_s6[s-1]});

			always_ff @(posedge clk) begin
				dv_rem_s6[s][l] <= ge ? dif[DMW-1:0] : shf[DMW-1:0];
				dv_q_s6[s][l]   <= {dv_q_s6[s-1][l][QW-2:0], ge};
				dv_ovf_s6[s][l] <= dv_ovf_s6[s-1][l];
				dv_neg_s6[s][l] <= dv_neg_s6[s-1][l];
			end
		end
	end

	// Sign, saturation and the singular case.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (dv_dz_s6[STEPS]) begin
				ent[k] = '0;
			end else if (dv_neg_s6[STEPS][k]) begin
				if (dv_ovf_s6[STEPS][k] || (dv_q_s6[STEPS][k] > mi3_pkg::SAT_NEG)) begin
					ent[k] = mi3_pkg::SAT_NEG;
				end else begin
					ent[k] = -dv_q_s6[STEPS][k];
				end
			end else begin
				if (dv_ovf_s6[STEPS][k] || dv_q_s6[STEPS][k][QW-1]) begin
					ent[k] = mi3_pkg::SAT_POS;
				end else begin
					ent[k] = dv_q_s6[STEPS][k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
			dv_dz_s6[STEPS]};
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ verif/matrix_inverse_3x3_test.sv @@
module matrix_inverse_3x3_test;

	// The block is a fixed pipeline. An item is taken at every rising edge at which
	// start is high and busy is low. Its result is shown for one cycle with done
	// high. This bench computes the inverse of every item it sends, adjugate over
	// determinant, and keeps those answers in arrival order. It checks each result
	// that comes out against the oldest answer still waiting.

	localparam int LATENCY = 38;
	localparam int RANDOM_ITEMS = 1350;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	mi3_pkg::mat_t  mat;
	logic  done;
	mi3_pkg::inv_t  res;

	mi3_pkg::inv_t  inverses_due[$];
	int    error_count = 0;

	matrix_inverse_3x3 DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mat(mat), .done(done), .res(res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// This is the safety net. The slowest correct run is about 1400 items, each with a
	// random idle gap, plus one drain of the pipeline. The limit allows several times
	// that.
	initial begin
		#(20 * 1000000);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Divide with the quotient truncated toward zero, then saturate to 32 bits.
	// The numerator is below 2^55 in magnitude, so it fits in 64 bits.
	function automatic logic [31:0] scaled_quotient(longint num, longint den);
		longint q;
		q = (num * 64'sd16777216) / den;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic mi3_pkg::inv_t invert(mi3_pkg::mat_t m);
		longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
		longint c11, c12, c13, c21, c22, c23, c31, c32, c33, det;
		mi3_pkg::inv_t r;
		a11 = m.m11; a12 = m.m12; a13 = m.m13;
		a21 = m.m21; a22 = m.m22; a23 = m.m23;
		a31 = m.m31; a32 = m.m32; a33 = m.m33;
		c11 = a22 * a33 - a23 * a32;
		c12 = a21 * a33 - a23 * a31;
		c13 = a21 * a32 - a22 * a31;
		c21 = a12 * a33 - a13 * a32;
		c22 = a11 * a33 - a13 * a31;
		c23 = a11 * a32 - a12 * a31;
		c31 = a12 * a23 - a13 * a22;
		c32 = a11 * a23 - a13 * a21;
		c33 = a11 * a22 - a12 * a21;
		det = a11 * c11 - a12 * c12 + a13 * c13;
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		// The adjugate is the transpose of the minors, with checkerboard signs.
		r.inv11 = scaled_quotient(c11, det);
		r.inv12 = scaled_quotient(-c21, det);
		r.inv13 = scaled_quotient(c31, det);
		r.inv21 = scaled_quotient(-c12, det);
		r.inv22 = scaled_quotient(c22, det);
		r.inv23 = scaled_quotient(-c32, det);
		r.inv31 = scaled_quotient(c13, det);
		r.inv32 = scaled_quotient(-c23, det);
		r.inv33 = scaled_quotient(c33, det);
		return r;
	endfunction

	// The result port is sampled at the rising edge. The bench drives with
	// nonblocking assignments, so the value seen at the edge does not depend on
	// event order.
	always @(posedge clk) begin
		mi3_pkg::inv_t want;
		if (arst_n && done) begin
			if (inverses_due.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = inverses_due.pop_front();
				if (res.inv11 !== want.inv11) report_mismatch($sformatf("inv11 %h want %h", res.inv11, want.inv11));
				if (res.inv12 !== want.inv12) report_mismatch($sformatf("inv12 %h want %h", res.inv12, want.inv12));
				if (res.inv13 !== want.inv13) report_mismatch($sformatf("inv13 %h want %h", res.inv13, want.inv13));
				if (res.inv21 !== want.inv21) report_mismatch($sformatf("inv21 %h want %h", res.inv21, want.inv21));
				if (res.inv22 !== want.inv22) report_mismatch($sformatf("inv22 %h want %h", res.inv22, want.inv22));
				if (res.inv23 !== want.inv23) report_mismatch($sformatf("inv23 %h want %h", res.inv23, want.inv23));
				if (res.inv31 !== want.inv31) report_mismatch($sformatf("inv31 %h want %h", res.inv31, want.inv31));
				if (res.inv32 !== want.inv32) report_mismatch($sformatf("inv32 %h want %h", res.inv32, want.inv32));
				if (res.inv33 !== want.inv33) report_mismatch($sformatf("inv33 %h want %h", res.inv33, want.inv33));
				if (res.singular !== want.singular) report_mismatch($sformatf("singular %b want %b", res.singular, want.singular));
			end
		end
	end

	// These are the directed matrices. Where a result can be read off at a glance,
	// it is typed in and checked as well.
	typedef struct {
		mi3_pkg::mat_t  m;
		bit    known;
		mi3_pkg::inv_t  r;
	} directed_row_t;

	localparam logic signed [15:0] ONE = 16'sh0100;
	localparam logic signed [15:0] MAXV = 16'sh7FFF;
	localparam logic signed [15:0] MINV = -16'sh8000;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	// The inverse of one raw unit is 2^24 raw units of the result.
	localparam logic [31:0] Q_UNIT_INV = 32'h0100_0000;

	directed_row_t directed_rows[$];

	function automatic mi3_pkg::mat_t make_mat(logic signed [15:0] a, b, c, d, e, f, g, h, i);
		mi3_pkg::mat_t m;
		m.m11 = a; m.m12 = b; m.m13 = c;
		m.m21 = d; m.m22 = e; m.m23 = f;
		m.m31 = g; m.m32 = h; m.m33 = i;
		return m;
	endfunction

	function automatic mi3_pkg::inv_t diag_result(logic [31:0] v);
		mi3_pkg::inv_t r;
		r = '0;
		r.inv11 = v; r.inv22 = v; r.inv33 = v;
		return r;
	endfunction

	// The sender holds start high for the whole item. It lowers start only when
	// it idles, so start never gets two writes in one step.
	task automatic send_item(mi3_pkg::mat_t m, bit known, mi3_pkg::inv_t r);
		mi3_pkg::inv_t want;
		want = invert(m);
		if (known && want !== r) report_mismatch("hand result disagrees with prediction");
		mat <= m;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		inverses_due.push_back(want);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 60);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			start <= 1'b0;
			mat <= mi3_pkg::mat_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 7))
			0: return MAXV;
			1: return MINV;
			2: return 16'sd0;
			3: return 16'(signed'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mi3_pkg::mat_t rand_matrix();
		mi3_pkg::mat_t m;
		int style;
		style = $urandom_range(0, 9);
		m = make_mat(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
			rand_entry(), rand_entry(), rand_entry(), rand_entry());
		// Rank deficient: a copied row, or a negated row without MINV, makes the determinant zero.
		if (style == 0) begin
			m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13;
		end else if (style == 1) begin
			m.m21 = -m.m11; m.m22 = -m.m12; m.m23 = -m.m13;
		end else if (style == 2) begin
			// Near the identity matrix, this gives ordinary well-scaled inverses.
			m = make_mat(ONE + 16'($urandom_range(0, 63)), 16'($urandom_range(0, 31)), 16'sd0,
				16'sd0, ONE, 16'($urandom_range(0, 31)), 16'($urandom_range(0, 31)), 16'sd0, ONE);
		end else if (style == 3) begin
			// Entries are tiny, so the determinant is tiny and the results are large.
			m = make_mat(16'($urandom_range(0, 3)), 16'sd0, 16'sd0, 16'sd0,
				16'($urandom_range(1, 3)), 16'sd0, 16'sd0, 16'sd0, 16'($urandom_range(1, 3)));
		end
		return m;
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mat = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// These are the directed rows.
		directed_rows.push_back('{make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, mi3_pkg::inv_t'(1)});
		directed_rows.push_back('{make_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, diag_result(Q_ONE)});
		directed_rows.push_back('{make_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
			diag_result(-Q_ONE)});
		directed_rows.push_back('{make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
			diag_result(Q_UNIT_INV)});
		directed_rows.push_back('{make_mat(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1,
			diag_result(-Q_UNIT_INV)});
		directed_rows.push_back('{make_mat(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV),
			1, mi3_pkg::inv_t'(1)});
		directed_rows.push_back('{make_mat(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
			1, mi3_pkg::inv_t'(1)});
		directed_rows.push_back('{make_mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 0, '0});
		directed_rows.push_back('{make_mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 0, '0});
		directed_rows.push_back('{make_mat(MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, MINV),
			0, '0});
		directed_rows.push_back('{make_mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MINV, MAXV),
			0, '0});
		directed_rows.push_back('{make_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, '0});
		directed_rows.push_back('{make_mat(2 * ONE, ONE, 0, ONE, 2 * ONE, ONE, 0, ONE, 2 * ONE),
			0, '0});
		directed_rows.push_back('{make_mat(3, 0, 0, 0, 7, 0, 0, 0, -5), 0, '0});
		directed_rows.push_back('{make_mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
			7 * ONE, 8 * ONE, 9 * ONE), 1, mi3_pkg::inv_t'(1)});
		directed_rows.push_back('{make_mat(16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB, 16'h0F0F,
			16'hF0F0, 16'h7F00, 16'h80FF, 16'h00FF), 0, '0});

		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].m, directed_rows[k].known, directed_rows[k].r);
			if (k % 4 == 3) idle_gap();
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_item(rand_matrix(), 0, '0);
			// The sender pauses here and lets the pipeline drain completely.
			if (n == RANDOM_ITEMS / 2) begin
				start <= 1'b0;
				while (inverses_due.size() != 0) @(posedge clk);
			end else begin
				idle_gap();
			end
		end
		start <= 1'b0;

		fork
			begin
				while (inverses_due.size() != 0) @(posedge clk);
				repeat (LATENCY + 5) @(posedge clk);
			end
			begin
				repeat (20 * LATENCY + 1000) @(posedge clk);
				report_mismatch("timed out waiting for results");
			end
		join_any
		disable fork;

		if (error_count == 0 && inverses_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
